// ----- src/tcvp_pkg.sv -----
// ----------------------------------------------------------------------------
// tcvp_pkg
// Shared widths, constants and the hand-off type for triangle cull/project.
// ----------------------------------------------------------------------------
package tcvp_pkg;

    localparam int HALF_W    = 12;
    localparam int CLIP_W    = 32;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 33;
    localparam int Q_W       = 16;
    localparam int DEPTH_W   = 15;
    localparam int LANES     = 9;
    localparam int CFG_IDX_W = 8;
    localparam int DEPTH_MAX = 32767;
    localparam int HALF_LIMIT = 2048;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 8'd1;

    // lane order per vertex
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    // classified triangle handed from front to back
    typedef struct packed {
        logic                         visible;
        logic [LANES-1:0][NUM_W-1:0]  num;
        logic [LANES-1:0][DEN_W-1:0]  den;
    } tri_work_t;

endpackage

// ----- src/tcvp_front.sv -----
// ----------------------------------------------------------------------------
// tcvp_front
// Trivial reject and forming of the projection dividends and divisors.
// ----------------------------------------------------------------------------
module tcvp_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic signed [tcvp_pkg::CLIP_W-1:0]  clip_x [3],
    input  logic signed [tcvp_pkg::CLIP_W-1:0]  clip_y [3],
    input  logic signed [tcvp_pkg::CLIP_W-1:0]  clip_z [3],
    input  logic signed [tcvp_pkg::CLIP_W-1:0]  clip_w [3],
    input  logic [tcvp_pkg::HALF_W-1:0]         hw_eff,
    input  logic [tcvp_pkg::HALF_W-1:0]         hh_eff,
    output logic                                work_valid,
    output tcvp_pkg::tri_work_t                 work
);
    import tcvp_pkg::*;

    logic      work_valid_reg;
    tri_work_t work_reg;
    tri_work_t work_next;

    logic signed [33:0] sx [3];
    logic signed [33:0] sy [3];
    logic signed [33:0] sz [3];
    logic signed [33:0] wv [3];
    logic signed [50:0] px [3];
    logic signed [50:0] py [3];
    logic signed [50:0] pz [3];
    logic signed [16:0] hwf;
    logic signed [16:0] hhf;
    logic signed [16:0] dmf;
    logic [2:0] w_ok;
    logic [2:0] lx, gx, ly, gy, lz, gz;
    logic       keep;

    // scale factors, half size times sixteen
    assign hwf = $signed({1'b0, hw_eff, 4'b0000});
    assign hhf = $signed({1'b0, hh_eff, 4'b0000});
    assign dmf = $signed(17'(DEPTH_MAX));

    // outcodes, w test and products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            wv[k]   = 34'(clip_w[k]);
            w_ok[k] = !clip_w[k][CLIP_W-1] && (clip_w[k] != '0);
            lx[k]   = 34'(clip_x[k]) < -wv[k];
            gx[k]   = 34'(clip_x[k]) > wv[k];
            ly[k]   = 34'(clip_y[k]) < -wv[k];
            gy[k]   = 34'(clip_y[k]) > wv[k];
            lz[k]   = 34'(clip_z[k]) < -wv[k];
            gz[k]   = 34'(clip_z[k]) > wv[k];
            sx[k]   = 34'(clip_x[k]) + wv[k];
            sy[k]   = wv[k] - 34'(clip_y[k]);
            sz[k]   = wv[k] - 34'(clip_z[k]);
            px[k]   = sx[k] * hwf;
            py[k]   = sy[k] * hhf;
            pz[k]   = sz[k] * dmf;
        end
        keep = (&w_ok) && !(&lx) && !(&gx) && !(&ly) && !(&gy) && !(&lz) && !(&gz);
        work_next.visible = keep;
        for (int k = 0; k < 3; k++)
        begin
            if (keep)
            begin
                work_next.num[3*k+LANE_X] = (px[k] > 0) ? NUM_W'(px[k]) : '0;
                work_next.num[3*k+LANE_Y] = (py[k] > 0) ? NUM_W'(py[k]) : '0;
                work_next.num[3*k+LANE_Z] = (pz[k] > 0) ? NUM_W'(pz[k]) : '0;
                work_next.den[3*k+LANE_X] = {1'b0, clip_w[k]};
                work_next.den[3*k+LANE_Y] = {1'b0, clip_w[k]};
                work_next.den[3*k+LANE_Z] = {clip_w[k], 1'b0};
            end
            else
            begin
                // zero dividend over unit divisor gives a zero field
                work_next.num[3*k+LANE_X] = '0;
                work_next.num[3*k+LANE_Y] = '0;
                work_next.num[3*k+LANE_Z] = '0;
                work_next.den[3*k+LANE_X] = DEN_W'(1);
                work_next.den[3*k+LANE_Y] = DEN_W'(1);
                work_next.den[3*k+LANE_Z] = DEN_W'(1);
            end
        end
    end

    // hand-off register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
        end
        else
        begin
            work_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign work_valid = work_valid_reg;
    assign work       = work_reg;

endmodule

// ----- src/tcvp_div.sv -----
// ----------------------------------------------------------------------------
// tcvp_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module tcvp_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 33,
    parameter int Q_W   = 16
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo,
    output logic             sat
);
    localparam int CMP_W = NUM_W + DEN_W + Q_W;

    logic [NUM_W-1:0] rem_reg [Q_W+1];
    logic [DEN_W-1:0] den_reg [Q_W+1];
    logic [Q_W-1:0]   quo_reg [Q_W+1];
    logic             sat_reg [Q_W+1];
    logic [NUM_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   quo_next [Q_W];
    logic [CMP_W-1:0] shifted  [Q_W];

    // one trial subtraction per stage, most significant bit first
    always_comb
    begin
        for (int s = 0; s < Q_W; s++)
        begin
            shifted[s] = CMP_W'(den_reg[s]) << (Q_W - 1 - s);
            if (CMP_W'(rem_reg[s]) >= shifted[s])
            begin
                rem_next[s] = rem_reg[s] - NUM_W'(shifted[s]);
                quo_next[s] = quo_reg[s] | (Q_W'(1) << (Q_W - 1 - s));
            end
            else
            begin
                rem_next[s] = rem_reg[s];
                quo_next[s] = quo_reg[s];
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        sat_reg[0] <= CMP_W'(num) >= (CMP_W'(den) << Q_W);
        for (int s = 0; s < Q_W; s++)
        begin
            rem_reg[s+1] <= rem_next[s];
            den_reg[s+1] <= den_reg[s];
            quo_reg[s+1] <= quo_next[s];
            sat_reg[s+1] <= sat_reg[s];
        end
    end

    assign quo = quo_reg[Q_W];
    assign sat = sat_reg[Q_W];

endmodule

// ----- src/tcvp_back.sv -----
// ----------------------------------------------------------------------------
// tcvp_back
// Nine divider lanes and the final clamp to screen and depth ranges.
// ----------------------------------------------------------------------------
module tcvp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        work_valid,
    input  tcvp_pkg::tri_work_t         work,
    input  logic [tcvp_pkg::HALF_W-1:0] hw_eff,
    input  logic [tcvp_pkg::HALF_W-1:0] hh_eff,
    output logic                        res_valid,
    output logic                        res_visible,
    output logic [tcvp_pkg::Q_W-1:0]    res_val [tcvp_pkg::LANES]
);
    import tcvp_pkg::*;

    localparam int LAT = Q_W + 1;

    logic [LAT-1:0]  vld_reg;
    logic [LAT-1:0]  vis_reg;
    logic            res_valid_reg;
    logic            res_visible_reg;
    logic [Q_W-1:0]  res_val_reg [LANES];
    logic [Q_W-1:0]  res_val_next [LANES];
    logic [Q_W-1:0]  quo [LANES];
    logic            sat [LANES];
    logic [Q_W-1:0]  top [LANES];
    logic [Q_W-1:0]  top_x;
    logic [Q_W-1:0]  top_y;
    logic [16:0]     top_x_full;
    logic [16:0]     top_y_full;

    // divider lanes
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        tcvp_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .Q_W   (Q_W)
        ) u_div (
            .clk (clk),
            .num (work.num[l]),
            .den (work.den[l]),
            .quo (quo[l]),
            .sat (sat[l])
        );
    end

    // clamp bounds from the live half sizes
    assign top_x_full = {hw_eff, 5'b00000} - 17'd16;
    assign top_y_full = {hh_eff, 5'b00000} - 17'd16;
    assign top_x      = top_x_full[Q_W-1:0];
    assign top_y      = top_y_full[Q_W-1:0];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            top[3*k+LANE_X] = top_x;
            top[3*k+LANE_Y] = top_y;
            top[3*k+LANE_Z] = Q_W'(DEPTH_MAX);
        end
        for (int l = 0; l < LANES; l++)
        begin
            if (sat[l] || (quo[l] > top[l]))
            begin
                res_val_next[l] = top[l];
            end
            else
            begin
                res_val_next[l] = quo[l];
            end
        end
    end

    // valid and visible travel alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[LAT-2:0], work_valid};
            res_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        vis_reg         <= {vis_reg[LAT-2:0], work.visible};
        res_visible_reg <= vis_reg[LAT-1];
        for (int l = 0; l < LANES; l++)
        begin
            res_val_reg[l] <= res_val_next[l];
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_visible = res_visible_reg;
    assign res_val     = res_val_reg;

endmodule

// ----- src/triangle_cull_and_viewport_project_top.sv -----
// ----------------------------------------------------------------------------
// triangle_cull_and_viewport_project_top
// Clip-space trivial reject and viewport transform of one triangle.
// ----------------------------------------------------------------------------
// A triangle is taken on any cycle with start high; busy never rises, so one
// triangle may follow another every cycle. Its result appears on done, with
// visible and the nine screen and depth fields, through the cull and product
// forming register, 17 stages of the pipelined restoring dividers (an input
// stage with the overflow check, then one quotient bit per stage, nine lanes in
// parallel), and one clamp stage. done is a one-cycle strobe that the receiver
// cannot hold off. Half sizes are written through cfg_valid/cfg_ready, which
// is always ready, and should only change while no triangle is in flight.
module triangle_cull_and_viewport_project_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [31:0]                   clip_x0,
    input  logic signed [31:0]                   clip_y0,
    input  logic signed [31:0]                   clip_z0,
    input  logic signed [31:0]                   clip_w0,
    input  logic signed [31:0]                   clip_x1,
    input  logic signed [31:0]                   clip_y1,
    input  logic signed [31:0]                   clip_z1,
    input  logic signed [31:0]                   clip_w1,
    input  logic signed [31:0]                   clip_x2,
    input  logic signed [31:0]                   clip_y2,
    input  logic signed [31:0]                   clip_z2,
    input  logic signed [31:0]                   clip_w2,
    output logic                                 done,
    output logic                                 visible,
    output logic [15:0]                          screen_x0,
    output logic [15:0]                          screen_y0,
    output logic [14:0]                          depth0,
    output logic [15:0]                          screen_x1,
    output logic [15:0]                          screen_y1,
    output logic [14:0]                          depth1,
    output logic [15:0]                          screen_x2,
    output logic [15:0]                          screen_y2,
    output logic [14:0]                          depth2,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tcvp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcvp_pkg::HALF_W-1:0]          cfg_data
);
    import tcvp_pkg::*;

    logic [HALF_W-1:0]  half_width_reg;
    logic [HALF_W-1:0]  half_height_reg;
    logic [HALF_W-1:0]  hw_eff;
    logic [HALF_W-1:0]  hh_eff;
    logic signed [CLIP_W-1:0] cx [3];
    logic signed [CLIP_W-1:0] cy [3];
    logic signed [CLIP_W-1:0] cz [3];
    logic signed [CLIP_W-1:0] cw [3];
    logic               take;
    logic               work_valid;
    tri_work_t          work;
    logic [Q_W-1:0]     res_val [LANES];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= 12'd320;
            half_height_reg <= 12'd224;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_HALF_WIDTH)
            begin
                half_width_reg <= cfg_data;
            end
            else if (cfg_index == REG_HALF_HEIGHT)
            begin
                half_height_reg <= cfg_data;
            end
        end
    end

    // half sizes held to one through the limit
    always_comb
    begin
        priority if (half_width_reg == '0)
            hw_eff = HALF_W'(1);
        else if (half_width_reg > HALF_W'(HALF_LIMIT))
            hw_eff = HALF_W'(HALF_LIMIT);
        else
            hw_eff = half_width_reg;
        priority if (half_height_reg == '0)
            hh_eff = HALF_W'(1);
        else if (half_height_reg > HALF_W'(HALF_LIMIT))
            hh_eff = HALF_W'(HALF_LIMIT);
        else
            hh_eff = half_height_reg;
    end

    assign cx[0] = clip_x0;
    assign cy[0] = clip_y0;
    assign cz[0] = clip_z0;
    assign cw[0] = clip_w0;
    assign cx[1] = clip_x1;
    assign cy[1] = clip_y1;
    assign cz[1] = clip_z1;
    assign cw[1] = clip_w1;
    assign cx[2] = clip_x2;
    assign cy[2] = clip_y2;
    assign cz[2] = clip_z2;
    assign cw[2] = clip_w2;

    tcvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .clip_x     (cx),
        .clip_y     (cy),
        .clip_z     (cz),
        .clip_w     (cw),
        .hw_eff     (hw_eff),
        .hh_eff     (hh_eff),
        .work_valid (work_valid),
        .work       (work)
    );

    tcvp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .work_valid  (work_valid),
        .work        (work),
        .hw_eff      (hw_eff),
        .hh_eff      (hh_eff),
        .res_valid   (done),
        .res_visible (visible),
        .res_val     (res_val)
    );

    // result fields
    assign screen_x0 = res_val[0];
    assign screen_y0 = res_val[1];
    assign depth0    = res_val[2][DEPTH_W-1:0];
    assign screen_x1 = res_val[3];
    assign screen_y1 = res_val[4];
    assign depth1    = res_val[5][DEPTH_W-1:0];
    assign screen_x2 = res_val[6];
    assign screen_y2 = res_val[7];
    assign depth2    = res_val[8][DEPTH_W-1:0];

endmodule

// ----- tb/sv/tb_triangle_cull_and_viewport_project_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_cull_and_viewport_project_top
// Self-checking bench for triangle cull and viewport projection. A queue of
// triangles and half-size writes feeds a clocked driver. Each accepted
// triangle is projected here in exact integer arithmetic. A clocked monitor
// compares every done strobe, field by field, with the oldest projection.
// ----------------------------------------------------------------------------
module tb_triangle_cull_and_viewport_project_top;
    import tcvp_pkg::*;

    localparam int  RUN_LIMIT   = 400000;
    localparam int  SETTLE_CYC  = 30;
    localparam int  RAND_PER_PH = 200;
    localparam int  CALM_ITEMS  = 200;

    typedef enum logic {ITEM_TRI, ITEM_CFG} item_kind_t;

    typedef struct packed {
        item_kind_t                 kind;
        logic                       calm;
        logic [CFG_IDX_W-1:0]       idx;
        logic [HALF_W-1:0]          data;
        logic [2:0][31:0]           x;
        logic [2:0][31:0]           y;
        logic [2:0][31:0]           z;
        logic [2:0][31:0]           w;
    } work_item_t;

    typedef struct packed {
        logic                       vis;
        logic [2:0][15:0]           sx;
        logic [2:0][15:0]           sy;
        logic [2:0][14:0]           dz;
    } screen_tri_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] clip_x0, clip_y0, clip_z0, clip_w0;
    logic signed [31:0] clip_x1, clip_y1, clip_z1, clip_w1;
    logic signed [31:0] clip_x2, clip_y2, clip_z2, clip_w2;
    logic done;
    logic visible;
    logic [15:0] screen_x0, screen_y0, screen_x1, screen_y1, screen_x2, screen_y2;
    logic [14:0] depth0, depth1, depth2;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HALF_W-1:0] cfg_data;

    work_item_t  pending_q[$];
    screen_tri_t projected_q[$];
    logic [HALF_W-1:0] half_w_reg;
    logic [HALF_W-1:0] half_h_reg;
    int gap_left;
    int quiet_cyc;
    int cycle_cnt;
    int err_cnt;

    triangle_cull_and_viewport_project_top dut (.*);

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // floor(num/den) limited to [0, top]
    function automatic longint div_limit(input longint num, input longint den,
                                         input longint top);
        longint q;
        if (num <= 0)
            return 0;
        q = num / den;
        return (q > top) ? top : q;
    endfunction

    function automatic longint half_used(input logic [HALF_W-1:0] h);
        if (h == 0)
            return 1;
        if (h > HALF_LIMIT)
            return HALF_LIMIT;
        return longint'(h);
    endfunction

    // cull and project one triangle with the current half sizes
    function automatic screen_tri_t project_triangle(input work_item_t t,
                                                     input logic [HALF_W-1:0] hwr,
                                                     input logic [HALF_W-1:0] hhr);
        screen_tri_t r;
        longint xs[3], ys[3], zs[3], ws[3];
        longint hw, hh;
        logic lx, gx, ly, gy, lz, gz;
        r = '0;
        lx = 1; gx = 1; ly = 1; gy = 1; lz = 1; gz = 1;
        for (int k = 0; k < 3; k++)
        begin
            xs[k] = longint'($signed(t.x[k]));
            ys[k] = longint'($signed(t.y[k]));
            zs[k] = longint'($signed(t.z[k]));
            ws[k] = longint'($signed(t.w[k]));
            if (ws[k] <= 0)
                return r;
        end
        for (int k = 0; k < 3; k++)
        begin
            lx &= xs[k] < -ws[k];
            gx &= xs[k] > ws[k];
            ly &= ys[k] < -ws[k];
            gy &= ys[k] > ws[k];
            lz &= zs[k] < -ws[k];
            gz &= zs[k] > ws[k];
        end
        if (lx | gx | ly | gy | lz | gz)
            return r;
        hw = half_used(hwr);
        hh = half_used(hhr);
        r.vis = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            r.sx[k] = 16'(div_limit((xs[k] + ws[k]) * hw * 16, ws[k], (2 * hw - 1) * 16));
            r.sy[k] = 16'(div_limit((ws[k] - ys[k]) * hh * 16, ws[k], (2 * hh - 1) * 16));
            r.dz[k] = 15'(div_limit((ws[k] - zs[k]) * DEPTH_MAX, 2 * ws[k], DEPTH_MAX));
        end
        return r;
    endfunction

    function automatic work_item_t tri_of(input logic [31:0] x0, y0, z0, w0,
                                          input logic [31:0] x1, y1, z1, w1,
                                          input logic [31:0] x2, y2, z2, w2);
        work_item_t t;
        t = '0;
        t.kind = ITEM_TRI;
        t.x = {x2, x1, x0};
        t.y = {y2, y1, y0};
        t.z = {z2, z1, z0};
        t.w = {w2, w1, w0};
        return t;
    endfunction

    function automatic work_item_t cfg_of(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [HALF_W-1:0] data);
        work_item_t t;
        t = '0;
        t.kind = ITEM_CFG;
        t.idx = idx;
        t.data = data;
        return t;
    endfunction

    // coordinate mostly within [-(3w+1), 3w+1], sometimes anywhere
    function automatic logic [31:0] rand_coord(input longint w);
        longint span;
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        span = 3 * w + 1;
        return 32'((longint'($urandom) * 4 + longint'($urandom_range(0, 3))) % (2 * span + 1)
                   - span);
    endfunction

    function automatic work_item_t rand_triangle();
        work_item_t t;
        longint wv;
        t = '0;
        t.kind = ITEM_TRI;
        for (int k = 0; k < 3; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                t.w[k] = $urandom;
            else
            begin
                wv = longint'({1'b0, $urandom} & 32'h7FFF_FFFF) >> $urandom_range(0, 30);
                if (wv == 0)
                    wv = 1;
                t.w[k] = 32'(wv);
            end
            wv = longint'($signed(t.w[k]));
            if (wv <= 0)
                wv = 1;
            t.x[k] = rand_coord(wv);
            t.y[k] = rand_coord(wv);
            t.z[k] = rand_coord(wv);
        end
        return t;
    endfunction

    task automatic add_directed();
        logic [31:0] one, big, neg;
        one = 32'h0001_0000;
        big = 32'h7FFF_FFFF;
        neg = 32'h8000_0000;
        // plain visible triangle
        pending_q.push_back(tri_of(0, 0, 0, one, 32'h8000, 32'hFFFF_8000, 32'h4000, one,
                                   32'hFFFF_0000, one, 32'hFFFF_0000, 32'h0002_0000));
        // zero w and most negative w
        pending_q.push_back(tri_of(0, 0, 0, one, 0, 0, 0, 0, 0, 0, 0, one));
        pending_q.push_back(tri_of(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, neg));
        // all three vertices beyond one plane, for each plane
        pending_q.push_back(tri_of(32'hFFFE_0000, 0, 0, one, 32'hFFFD_0000, 0, 0, one,
                                   32'hFFFE_FFFF, 0, 0, one));
        pending_q.push_back(tri_of(32'h0002_0000, 0, 0, one, 32'h0001_0001, 0, 0, one,
                                   big, 0, 0, one));
        pending_q.push_back(tri_of(0, 32'hFFFE_0000, 0, one, 0, neg, 0, one,
                                   0, 32'hFFFE_FFFF, 0, one));
        pending_q.push_back(tri_of(0, 32'h0002_0000, 0, one, 0, big, 0, one,
                                   0, 32'h0001_0001, 0, one));
        pending_q.push_back(tri_of(0, 0, 32'hFFFE_0000, one, 0, 0, neg, one,
                                   0, 0, 32'hFFFE_FFFF, one));
        pending_q.push_back(tri_of(0, 0, 32'h0002_0000, one, 0, 0, big, one,
                                   0, 0, 32'h0001_0001, one));
        // straddling planes: clamps at both ends
        pending_q.push_back(tri_of(32'hFFFE_0000, 32'h0002_0000, 32'hFFFE_0000, one,
                                   32'h0002_0000, 32'hFFFE_0000, 32'h0002_0000, one,
                                   0, 0, 0, one));
        // extreme magnitudes, points exactly on the planes
        pending_q.push_back(tri_of(big, 32'h8000_0001, big, big, 32'h8000_0001, big,
                                   32'h8000_0001, big, neg, 0, 0, big));
        pending_q.push_back(tri_of(1, 1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                   0, 0, 0, 1));
        pending_q.push_back(tri_of(32'hFFFF_0000, one, one, one, 32'hFFFF_0000, one, one, one,
                                   32'hFFFF_0000, one, one, one));
        pending_q.push_back(tri_of(big, big, big, 1, neg, neg, neg, 1, 0, 0, 0, big));
        pending_q.push_back(tri_of(32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F, 32'h5555_5555,
                                   32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 32'h4000_0000,
                                   0, 0, 0, 32'h0000_0001));
    endtask

    // build the whole run: phases of half sizes, each with directed and random items
    initial
    begin
        logic [HALF_W-1:0] ph_w[9];
        logic [HALF_W-1:0] ph_h[9];
        work_item_t t;
        ph_w = '{12'(320), 12'(1), 12'(2048), 12'(0), 12'(4095), 12'(1), 12'(2047),
                 12'(640), 12'(320)};
        ph_h = '{12'(224), 12'(1), 12'(2048), 12'(4095), 12'(0), 12'(2048), 12'(3),
                 12'(480), 12'(224)};
        for (int p = 0; p < 9; p++)
        begin
            if (p == 5 || p == 6)
            begin
                ph_w[p] = 12'($urandom_range(1, 4095));
                ph_h[p] = 12'($urandom_range(1, 4095));
            end
            if (p > 0)
            begin
                pending_q.push_back(cfg_of(REG_HALF_WIDTH, ph_w[p]));
                pending_q.push_back(cfg_of(REG_HALF_HEIGHT, ph_h[p]));
            end
            if (p == 8)
                pending_q.push_back(cfg_of(8'($urandom_range(2, 255)), 12'($urandom)));
            add_directed();
            for (int i = 0; i < ((p == 8) ? CALM_ITEMS : RAND_PER_PH); i++)
            begin
                t = rand_triangle();
                t.calm = (p == 8);
                pending_q.push_back(t);
            end
        end
    end

    // driver: one transfer per accepted start, half-size writes only when idle
    always @(posedge clk or negedge rst_n)
    begin
        work_item_t t;
        if (!rst_n)
        begin
            start      <= 1'b0;
            cfg_valid  <= 1'b0;
            cfg_index  <= '0;
            cfg_data   <= '0;
            {clip_x0, clip_y0, clip_z0, clip_w0} <= '0;
            {clip_x1, clip_y1, clip_z1, clip_w1} <= '0;
            {clip_x2, clip_y2, clip_z2, clip_w2} <= '0;
            half_w_reg <= 12'd320;
            half_h_reg <= 12'd224;
            gap_left   <= 0;
            quiet_cyc  <= 0;
        end
        else
        begin
            int gap;
            gap = gap_left;
            // transfer at this edge
            if (start && !busy)
            begin
                t = pending_q.pop_front();
                projected_q.push_back(project_triangle(t, half_w_reg, half_h_reg));
                if (!t.calm && $urandom_range(0, 5) == 0)
                    gap = $urandom_range(1, 16);
            end
            else if (cfg_valid && cfg_ready)
            begin
                t = pending_q.pop_front();
                if (t.idx == REG_HALF_WIDTH)
                    half_w_reg <= t.data;
                else if (t.idx == REG_HALF_HEIGHT)
                    half_h_reg <= t.data;
                quiet_cyc <= 0;
            end
            else
                quiet_cyc <= (projected_q.size() == 0) ? quiet_cyc + 1 : 0;

            // next cycle
            if (gap > 0 || pending_q.size() == 0)
            begin
                gap_left  <= (gap > 0) ? gap - 1 : 0;
                start     <= 1'b0;
                cfg_valid <= 1'b0;
            end
            else
            begin
                t = pending_q[0];
                gap_left <= 0;
                if (t.kind == ITEM_TRI)
                begin
                    start     <= 1'b1;
                    cfg_valid <= 1'b0;
                    {clip_x0, clip_y0, clip_z0, clip_w0} <= {t.x[0], t.y[0], t.z[0], t.w[0]};
                    {clip_x1, clip_y1, clip_z1, clip_w1} <= {t.x[1], t.y[1], t.z[1], t.w[1]};
                    {clip_x2, clip_y2, clip_z2, clip_w2} <= {t.x[2], t.y[2], t.z[2], t.w[2]};
                end
                else
                begin
                    start     <= 1'b0;
                    cfg_valid <= (projected_q.size() == 0 && quiet_cyc >= SETTLE_CYC);
                    cfg_index <= t.idx;
                    cfg_data  <= t.data;
                end
            end
        end
    end

    // monitor: compare each done strobe with the oldest projection
    always @(posedge clk)
    begin
        screen_tri_t e;
        if (rst_n && done)
        begin
            if (projected_q.size() == 0)
            begin
                $error("result with no triangle outstanding");
                err_cnt++;
            end
            else
            begin
                e = projected_q.pop_front();
                if (visible !== e.vis)
                begin
                    $error("visible: expected %0d, got %0d", e.vis, visible);
                    err_cnt++;
                end
                for (int k = 0; k < 3; k++)
                begin
                    logic [15:0] gx, gy;
                    logic [14:0] gd;
                    gx = (k == 0) ? screen_x0 : (k == 1) ? screen_x1 : screen_x2;
                    gy = (k == 0) ? screen_y0 : (k == 1) ? screen_y1 : screen_y2;
                    gd = (k == 0) ? depth0 : (k == 1) ? depth1 : depth2;
                    if (gx !== e.sx[k])
                    begin
                        $error("screen_x%0d: expected %0d, got %0d", k, e.sx[k], gx);
                        err_cnt++;
                    end
                    if (gy !== e.sy[k])
                    begin
                        $error("screen_y%0d: expected %0d, got %0d", k, e.sy[k], gy);
                        err_cnt++;
                    end
                    if (gd !== e.dz[k])
                    begin
                        $error("depth%0d: expected %0d, got %0d", k, e.dz[k], gd);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        cycle_cnt = 0;
        err_cnt = 0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        wait (pending_q.size() == 0);
        wait (projected_q.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);
        if (err_cnt == 0 && projected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
src/tcvp_pkg.sv
src/tcvp_front.sv
src/tcvp_div.sv
src/tcvp_back.sv
src/triangle_cull_and_viewport_project_top.sv
tb/sv/tb_triangle_cull_and_viewport_project_top.sv
